@@ design/rlms_pkg.sv @@
// Shared types and constants of the RGB LED matrix scan controller.
package rlms_pkg;

    // Input operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Configuration register indexes, decoded from paddr[2]
    localparam logic REG_ON_TICKS  = 1'b0;
    localparam logic REG_OFF_TICKS = 1'b1;

    // Frame geometry fixed by the field widths
    localparam int STORE_ROWS = 32;
    localparam int ROW_W      = 5;
    localparam int SCAN_ROW_W = 6;
    localparam int COL_W      = 6;
    localparam int PLANE_W    = 2;
    localparam int WORD_W     = 32;
    localparam int LINE_W     = 64;
    localparam int TICKS_W    = 10;
    localparam int LADDR_W    = 4;

    // Scan status handed from the scan sequencer to the top level
    typedef struct packed {
        logic               word_valid;
        logic               latch_pulse;
        logic               output_enable;
        logic               upper_half;
        logic [LADDR_W-1:0] line_address;
    } scan_stat_t;

endpackage

@@ design/rlms_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module rlms_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 96,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write the entry and register the read word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/rlms_frame_store.sv @@
// Frame store: row-word RAM with per-entry valid bits, so a frame clear drops every entry together.
module rlms_frame_store #(
    parameter int COLOUR_PLANES = 3,
    localparam int DEPTH = COLOUR_PLANES * rlms_pkg::STORE_ROWS,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [AW-1:0]              rd_addr,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [rlms_pkg::LINE_W-1:0] wr_data,
    input  logic                       clear_all,
    output logic [rlms_pkg::LINE_W-1:0] rd_data
);
    import rlms_pkg::*;

    logic [DEPTH-1:0]  valid_reg;
    logic              rd_valid_reg;
    logic [LINE_W-1:0] ram_q;

    rlms_ram #(
        .WIDTH (LINE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // Track written entries; drop them all on a frame clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (clear_all)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // An entry never written since the last clear reads as dark
    assign rd_data = rd_valid_reg ? ram_q : '0;

endmodule

@@ design/rlms_scan.sv @@
// Scan sequencer: shift, latch, on and off phases per line pair.
module rlms_scan #(
    parameter int SCAN_LINES = 16,
    parameter int COLOUR_PLANES = 3,
    localparam int SL_W = $clog2(SCAN_LINES),
    localparam int WORDS = 4 * COLOUR_PLANES,
    localparam int WI_W = $clog2(WORDS)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic [rlms_pkg::TICKS_W-1:0]   on_ticks,
    input  logic [rlms_pkg::TICKS_W-1:0]   off_ticks,
    output logic [rlms_pkg::PLANE_W-1:0]   rd_plane,
    output logic [rlms_pkg::SCAN_ROW_W-1:0] rd_row,
    output rlms_pkg::scan_stat_t           stat
);
    import rlms_pkg::*;

    typedef enum logic [1:0] {
        PH_SHIFT,
        PH_LATCH,
        PH_ON,
        PH_OFF
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [SL_W-1:0]    line_reg, line_next;
    logic [WI_W-1:0]    word_reg, word_next;
    logic [TICKS_W-1:0] timer_reg, timer_next;
    logic [TICKS_W-1:0] timer_inc;
    logic [SL_W-1:0]    line_inc;
    logic [PLANE_W-1:0] group;

    assign timer_inc = timer_reg + 1'b1;
    assign line_inc  = (line_reg == SL_W'(SCAN_LINES - 1)) ? '0 : line_reg + 1'b1;

    // Work out the scan state after one tick
    always_comb
    begin
        phase_next = phase_reg;
        line_next  = line_reg;
        word_next  = word_reg;
        timer_next = timer_reg;
        case (phase_reg)
            PH_SHIFT:
            begin
                if (word_reg == WI_W'(WORDS - 1))
                begin
                    word_next  = '0;
                    phase_next = PH_LATCH;
                end
                else
                begin
                    word_next = word_reg + 1'b1;
                end
            end
            PH_LATCH:
            begin
                timer_next = '0;
                if (on_ticks != '0)
                begin
                    phase_next = PH_ON;
                end
                else if (off_ticks != '0)
                begin
                    phase_next = PH_OFF;
                end
                else
                begin
                    line_next  = line_inc;
                    word_next  = '0;
                    phase_next = PH_SHIFT;
                end
            end
            PH_ON:
            begin
                timer_next = timer_inc;
                if (timer_inc >= on_ticks || timer_inc == '0)
                begin
                    timer_next = '0;
                    if (off_ticks != '0)
                    begin
                        phase_next = PH_OFF;
                    end
                    else
                    begin
                        line_next  = line_inc;
                        word_next  = '0;
                        phase_next = PH_SHIFT;
                    end
                end
            end
            default:
            begin
                timer_next = timer_inc;
                if (timer_inc >= off_ticks || timer_inc == '0)
                begin
                    timer_next = '0;
                    line_next  = line_inc;
                    word_next  = '0;
                    phase_next = PH_SHIFT;
                end
            end
        endcase
    end

    // Hold the scan state; advance once per tick item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SHIFT;
            line_reg  <= '0;
            word_reg  <= '0;
            timer_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            line_reg  <= line_next;
            word_reg  <= word_next;
            timer_reg <= timer_next;
        end
    end

    // Word order: highest plane first; within a plane, row line+SCAN_LINES, then row line
    assign group    = PLANE_W'(word_reg >> 2);
    assign rd_plane = PLANE_W'(COLOUR_PLANES - 1) - group;
    assign rd_row   = word_reg[1] ? SCAN_ROW_W'(line_reg)
                                  : SCAN_ROW_W'(line_reg) + SCAN_ROW_W'(SCAN_LINES);

    assign stat.word_valid    = (phase_reg == PH_SHIFT);
    assign stat.latch_pulse   = (phase_reg == PH_LATCH);
    assign stat.output_enable = (phase_reg == PH_ON);
    assign stat.upper_half    = ~word_reg[0];
    assign stat.line_address  = LADDR_W'(line_reg);

endmodule

@@ design/rgb_led_matrix_scan_controller.sv @@
// Top level of the RGB LED matrix scan controller: item control, registers, output stage.
//
// Each input item is accepted in the idle state, which issues the frame-store read, and is
// finished in the execute state, which writes the modified row word back (pixel write),
// drops all valid bits (frame clear) or loads the output register (tick); the store's read
// data is registered. s_tready is low until the item is finished. A tick whose result finds
// the output register still full waits in the execute state until the register is taken.
// A clear works through per-entry valid bits, with no clearing pass after reset. Operation
// code 3 and pixel writes to an unused colour plane pass through without effect or result.
module rgb_led_matrix_scan_controller #(
    parameter int SCAN_LINES = 16,
    parameter int COLOUR_PLANES = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // pixel_on[0], column[6:1], row[11:7], colour_plane[13:12]
    input  logic [1:0]  s_tuser,  // operation[1:0]
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // word_valid[0], data_word[32:1], line_address[36:33],
                                  // latch_pulse[37], output_enable[38]
);
    import rlms_pkg::*;

    localparam int DEPTH = COLOUR_PLANES * STORE_ROWS;
    localparam int AW = $clog2(DEPTH);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    ctrl_state_t        state_reg;
    logic [1:0]         op_reg;
    logic               pixel_on_reg;
    logic [COL_W-1:0]   column_reg;
    logic               plane_ok_reg;
    logic [AW-1:0]      addr_reg;
    logic [TICKS_W-1:0] on_ticks_reg;
    logic [TICKS_W-1:0] off_ticks_reg;
    logic               out_valid_reg;
    logic [39:0]        out_data_reg;

    logic               in_pixel_on;
    logic [COL_W-1:0]   in_column;
    logic [ROW_W-1:0]   in_row;
    logic [PLANE_W-1:0] in_plane;
    logic               in_plane_ok;
    logic [AW-1:0]      pixel_addr;
    logic [AW-1:0]      scan_addr;
    logic [AW-1:0]      rd_addr;
    logic [LINE_W-1:0]  rd_data;
    logic [LINE_W-1:0]  bit_mask;
    logic [LINE_W-1:0]  merged;
    logic               wr_en;
    logic               clear_all;
    logic               out_free;
    logic               tick_done;
    logic               accept;
    logic               cfg_wr;
    logic [PLANE_W-1:0] scan_plane;
    logic [SCAN_ROW_W-1:0] scan_row;
    logic [WORD_W-1:0]  shift_word;
    scan_stat_t         stat;

    // Unpack the input item
    assign in_pixel_on = s_tdata[0];
    assign in_column   = s_tdata[6:1];
    assign in_row      = s_tdata[11:7];
    assign in_plane    = s_tdata[13:12];
    assign in_plane_ok = (in_plane < PLANE_W'(COLOUR_PLANES));

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_ticks_reg  <= TICKS_W'(256);
            off_ticks_reg <= TICKS_W'(256);
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_ON_TICKS:  on_ticks_reg  <= pwdata[TICKS_W-1:0];
                REG_OFF_TICKS: off_ticks_reg <= pwdata[TICKS_W-1:0];
                default:       on_ticks_reg  <= on_ticks_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ON_TICKS:  prdata = 32'(on_ticks_reg);
            REG_OFF_TICKS: prdata = 32'(off_ticks_reg);
            default:       prdata = '0;
        endcase
    end

    // Scan sequencer
    rlms_scan #(
        .SCAN_LINES    (SCAN_LINES),
        .COLOUR_PLANES (COLOUR_PLANES)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (tick_done),
        .on_ticks  (on_ticks_reg),
        .off_ticks (off_ticks_reg),
        .rd_plane  (scan_plane),
        .rd_row    (scan_row),
        .stat      (stat)
    );

    // Pick the read address: the scanned row for a tick, else the pixel's row
    assign pixel_addr = in_plane_ok ? AW'({in_plane, in_row}) : '0;
    assign scan_addr  = AW'({scan_plane, scan_row[ROW_W-1:0]});

    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            rd_addr = (s_tuser == OP_TICK) ? scan_addr : pixel_addr;
        end
        else
        begin
            rd_addr = addr_reg;
        end
    end

    rlms_frame_store #(
        .COLOUR_PLANES (COLOUR_PLANES)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr   (rd_addr),
        .wr_en     (wr_en),
        .wr_addr   (addr_reg),
        .wr_data   (merged),
        .clear_all (clear_all),
        .rd_data   (rd_data)
    );

    // Merge the pixel bit into the row word; column 0 sits in the top bit
    assign bit_mask = LINE_W'(1) << (COL_W'(LINE_W - 1) - column_reg);
    assign merged   = pixel_on_reg ? (rd_data | bit_mask) : (rd_data & ~bit_mask);

    assign wr_en     = (state_reg == ST_EXEC) && (op_reg == OP_WRITE) && plane_ok_reg;
    assign clear_all = (state_reg == ST_EXEC) && (op_reg == OP_CLEAR);
    assign out_free  = !out_valid_reg || m_tready;
    assign tick_done = (state_reg == ST_EXEC) && (op_reg == OP_TICK) && out_free;

    // Rows past the store, and every phase but shift, shift out a dark word
    always_comb
    begin
        if (!stat.word_valid || scan_row[SCAN_ROW_W-1])
        begin
            shift_word = '0;
        end
        else if (stat.upper_half)
        begin
            shift_word = rd_data[LINE_W-1:WORD_W];
        end
        else
        begin
            shift_word = rd_data[WORD_W-1:0];
        end
    end

    // Item control: capture on accept, finish in the execute state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_WRITE;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_EXEC;
                        op_reg    <= s_tuser;
                    end
                end
                ST_EXEC:
                begin
                    if (op_reg != OP_TICK || out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Item payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pixel_on_reg <= in_pixel_on;
            column_reg   <= in_column;
            plane_ok_reg <= in_plane_ok;
            addr_reg     <= rd_addr;
        end
    end

    // Output stage: load on a finished tick, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (tick_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_done)
        begin
            out_data_reg <= {1'b0, stat.output_enable, stat.latch_pulse,
                             stat.line_address, shift_word, stat.word_valid};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A result only ever comes from a tick in the execute state
    a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_EXEC && op_reg == OP_TICK))
        else $error("result item without a tick");

    // An accepted item always moves to the execute state
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_EXEC)
        else $error("accepted item not executed");

    // Shift, latch and enable phases never overlap in one result
    a_phase_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $countones({m_tdata[0], m_tdata[37], m_tdata[38]}) <= 1)
        else $error("overlapping scan phases in a result");

    // The frame store is written only while executing a pixel write
    a_write_gate: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !clear_all && !tick_done)
        else $error("store write outside a pixel write");

endmodule

@@ tb/rgb_led_matrix_scan_controller_tb.sv @@
// Self-checking testbench of the RGB LED matrix scan controller with a built-in scan predictor.
module rgb_led_matrix_scan_controller_tb;
    import rlms_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int NUM_PLANES    = 3;
    localparam int NUM_LINES     = 16;
    localparam int WORDS_PER_LINE = 4 * NUM_PLANES;
    localparam int CLK_HALF      = 4;

    typedef enum logic [1:0] {SCAN_SHIFT, SCAN_LATCH, SCAN_ON, SCAN_OFF} scan_phase_t;

    typedef struct packed {
        logic [1:0]       op;
        logic             pixel_on;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic [1:0]       plane;
    } pixel_item_t;

    // Matches m_tdata[38:0] from the top bit down
    typedef struct packed {
        logic               output_enable;
        logic               latch_pulse;
        logic [LADDR_W-1:0] line_address;
        logic [WORD_W-1:0]  data_word;
        logic               word_valid;
    } pin_state_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    // Predictor state
    logic [LINE_W-1:0]  frame_bits [NUM_PLANES][STORE_ROWS];
    scan_phase_t        scan_phase;
    logic [LADDR_W-1:0] scan_line;
    logic [3:0]         word_idx;
    logic [TICKS_W-1:0] phase_tmr;
    logic [TICKS_W-1:0] on_cfg;
    logic [TICKS_W-1:0] off_cfg;

    pixel_item_t pending_items [$];
    pin_state_t  pin_states_due [$];
    int          fail_count = 0;
    bit          no_idle = 1'b0;
    int          hold_request = 0;
    int          hold_served = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          hold_left = 0;

    rgb_led_matrix_scan_controller i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Move the scan on to the next line pair, wrapping after the last one
    function automatic void advance_line();
        scan_line  = LADDR_W'((int'(scan_line) + 1) % NUM_LINES);
        word_idx   = '0;
        phase_tmr  = '0;
        scan_phase = SCAN_SHIFT;
    endfunction

    // Enter the off period, or skip it when it has zero length
    function automatic void start_off();
        phase_tmr = '0;
        if (off_cfg != '0)
            scan_phase = SCAN_OFF;
        else
            advance_line();
    endfunction

    // Compute the pin state of one tick and advance the scan
    function automatic pin_state_t scan_tick();
        pin_state_t        r;
        logic [LINE_W-1:0] line_word;
        int                grp;
        int                part;
        r = '0;
        r.line_address = scan_line;
        case (scan_phase)
            SCAN_SHIFT:
            begin
                grp  = int'(word_idx) / 4;
                part = int'(word_idx) % 4;
                if (part < 2)
                    line_word = frame_bits[NUM_PLANES-1-grp][{1'b1, scan_line}];
                else
                    line_word = frame_bits[NUM_PLANES-1-grp][{1'b0, scan_line}];
                r.word_valid = 1'b1;
                r.data_word  = part[0] ? line_word[31:0] : line_word[63:32];
                word_idx = word_idx + 1'b1;
                if (word_idx == WORDS_PER_LINE)
                begin
                    word_idx   = '0;
                    scan_phase = SCAN_LATCH;
                end
            end
            SCAN_LATCH:
            begin
                r.latch_pulse = 1'b1;
                phase_tmr = '0;
                if (on_cfg != '0)
                    scan_phase = SCAN_ON;
                else
                    start_off();
            end
            SCAN_ON:
            begin
                r.output_enable = 1'b1;
                phase_tmr = phase_tmr + 1'b1;
                if (phase_tmr >= on_cfg || phase_tmr == '0)
                    start_off();
            end
            default:
            begin
                phase_tmr = phase_tmr + 1'b1;
                if (phase_tmr >= off_cfg || phase_tmr == '0)
                    advance_line();
            end
        endcase
        return r;
    endfunction

    // Apply one accepted item to the predicted frame and scan
    function automatic void apply_item(logic [1:0] op, logic [15:0] d);
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [1:0]       plane;
        col   = d[6:1];
        row   = d[11:7];
        plane = d[13:12];
        case (op)
            OP_WRITE:
            begin
                if (plane < NUM_PLANES)
                    frame_bits[plane][row][LINE_W-1-col] = d[0];
            end
            OP_CLEAR:
            begin
                for (int p = 0; p < NUM_PLANES; p++)
                    for (int i = 0; i < STORE_ROWS; i++)
                        frame_bits[p][i] = '0;
            end
            OP_TICK:
                pin_states_due.push_back(scan_tick());
            default:
            begin
            end
        endcase
    endfunction

    // Offer items from the pending queue, with random idle bursts
    always @(posedge clk or negedge rst_n)
    begin
        pixel_item_t it;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                apply_item(s_tuser, s_tdata);
            if (s_tvalid && !s_tready)
            begin
            end
            else if (send_gap != 0)
            begin
                send_gap = send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_items.size() == 0)
                s_tvalid <= 1'b0;
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                send_gap = $urandom_range(0, 11);
                s_tvalid <= 1'b0;
            end
            else
            begin
                it = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= it.op;
                s_tdata  <= {2'b00, it.plane, it.row, it.column, it.pixel_on};
            end
        end
    end

    // Drive the receiver ready: random bursts, plus a long hold on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_served != hold_request)
        begin
            hold_served = hold_request;
            hold_left = 200;
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (recv_gap != 0)
        begin
            recv_gap = recv_gap - 1;
            m_tready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            recv_gap = $urandom_range(0, 11);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Compare each accepted result with the oldest predicted pin state
    always @(posedge clk)
    begin
        pin_state_t want;
        pin_state_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[38:0];
            if (pin_states_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result item: %h", m_tdata);
            end
            else
            begin
                want = pin_states_due.pop_front();
                if (got.word_valid !== want.word_valid || got.data_word !== want.data_word ||
                    got.line_address !== want.line_address ||
                    got.latch_pulse !== want.latch_pulse ||
                    got.output_enable !== want.output_enable)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: exp valid %b word %h line %0d latch %b oe %b",
                            want.word_valid, want.data_word, want.line_address,
                            want.latch_pulse, want.output_enable,
                            ", got valid %b word %h line %0d latch %b oe %b",
                            got.word_valid, got.data_word, got.line_address,
                            got.latch_pulse, got.output_enable);
                end
            end
        end
    end

    // Write one register, then read it back
    task automatic cfg_write(logic idx, logic [TICKS_W-1:0] value);
        logic [31:0] rd;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ON_TICKS)
            on_cfg = value;
        else
            off_cfg = value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== 32'(value))
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("register %0d readback: exp %h got %h", idx, 32'(value), rd);
        end
    endtask

    task automatic push_item(logic [1:0] op, logic pix, int col, int row, int plane);
        pixel_item_t it;
        it.op       = op;
        it.pixel_on = pix;
        it.column   = COL_W'(col);
        it.row      = ROW_W'(row);
        it.plane    = 2'(plane);
        pending_items.push_back(it);
    endtask

    // Queue random items: mostly ticks and pixel writes, a few clears and unused codes
    task automatic push_random(int count);
        pixel_item_t it;
        int          pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            it = pixel_item_t'(16'($urandom));
            if (pick < 68)
                it.op = OP_TICK;
            else if (pick < 94)
                it.op = OP_WRITE;
            else if (pick < 96)
                it.op = OP_CLEAR;
            else
                it.op = OP_UNUSED;
            pending_items.push_back(it);
        end
    endtask

    // Wait until every item is sent and every result is in, then let the block settle
    task automatic drain();
        while (pending_items.size() != 0 || s_tvalid || pin_states_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic run_phase(logic [TICKS_W-1:0] on_val, logic [TICKS_W-1:0] off_val,
                             int count);
        drain();
        cfg_write(REG_ON_TICKS, on_val);
        cfg_write(REG_OFF_TICKS, off_val);
        push_random(count);
    endtask

    initial
    begin
        for (int p = 0; p < NUM_PLANES; p++)
            for (int i = 0; i < STORE_ROWS; i++)
                frame_bits[p][i] = '0;
        scan_phase = SCAN_SHIFT;
        scan_line  = '0;
        word_idx   = '0;
        phase_tmr  = '0;
        on_cfg     = 10'd256;
        off_cfg    = 10'd256;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: corner pixels, ignored plane, unused code, one full line of words
        push_item(OP_WRITE, 1'b1, 0, 0, 0);
        push_item(OP_WRITE, 1'b1, 63, 16, 1);
        push_item(OP_WRITE, 1'b1, 0, 31, 2);
        push_item(OP_WRITE, 1'b1, 63, 16, 2);
        push_item(OP_WRITE, 1'b1, 32, 0, 2);
        push_item(OP_WRITE, 1'b1, 31, 15, 0);
        push_item(OP_WRITE, 1'b1, 5, 0, 3);
        push_item(OP_WRITE, 1'b1, 0, 16, 2);
        push_item(OP_WRITE, 1'b0, 0, 16, 2);
        push_item(OP_UNUSED, 1'b1, 63, 31, 3);
        for (int i = 0; i < WORDS_PER_LINE + 3; i++)
            push_item(OP_TICK, 1'b0, 0, 0, 0);
        push_item(OP_CLEAR, 1'b0, 0, 0, 0);
        push_random(60);

        // Settings: zero-length periods and extremes
        run_phase(10'd0, 10'd0, 220);
        run_phase(10'd1, 10'd0, 200);
        run_phase(10'd0, 10'd1, 200);
        run_phase(10'd1023, 10'd1023, 120);

        // Hold off the receiver while ticks keep coming
        drain();
        cfg_write(REG_ON_TICKS, 10'd4);
        cfg_write(REG_OFF_TICKS, 10'd3);
        hold_request = hold_request + 1;
        for (int i = 0; i < 40; i++)
            push_item(OP_TICK, 1'b0, 0, 0, 0);
        push_random(160);

        // Closing stretch with no idling
        drain();
        no_idle = 1'b1;
        cfg_write(REG_ON_TICKS, 10'd2);
        cfg_write(REG_OFF_TICKS, 10'd5);
        push_random(250);
        drain();
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #(2 * CLK_HALF * 600000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
design/rlms_pkg.sv
design/rlms_ram.sv
design/rlms_frame_store.sv
design/rlms_scan.sv
design/rgb_led_matrix_scan_controller.sv
tb/rgb_led_matrix_scan_controller_tb.sv
